@@ hw/rtl/snu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snu_pkg: shared definitions of the surface normal unit
// Shape codes, fixed-point constants and the payload records that ride along
// the pipeline next to the arithmetic.
// ----------------------------------------------------------------------------
package snu_pkg;

  // Shape selector codes
  localparam logic [1:0] MODE_SPHERE   = 2'd0;
  localparam logic [1:0] MODE_FLAT     = 2'd1;
  localparam logic [1:0] MODE_CYLINDER = 2'd2;

  // Fraction bits of axis and normal values (Q2.30); 1.0 is 1 << AXIS_FRAC
  localparam int AXIS_FRAC = 30;

  // Saturated normal components
  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  // Pipeline depth figures
  localparam int SQRT_STEPS = 32;   // one root bit per stage
  localparam int DIV_STEPS  = 31;   // one quotient bit per stage

  // Item record carried from the front end to the divider setup
  typedef struct packed {
    logic [1:0]       mode;
    logic [2:0][32:0] t;       // hit - centre, signed Q17.16, exact
    logic [2:0][31:0] ax;      // axis or stored normal, signed Q2.30
    logic [30:0]      radius;
  } base_t;

  // Normalized cylinder radial vector
  typedef struct packed {
    logic [2:0]       neg;
    logic             degen;
    logic [2:0][30:0] m;
  } cyl_t;

  // What the output stage needs besides the quotients
  typedef struct packed {
    logic [1:0]       mode;
    logic [2:0][31:0] ax;
    logic [2:0]       neg;
    logic [2:0]       sat;
    logic [2:0]       zero;
    logic             degen;
  } tail_t;

endpackage

@@ hw/rtl/surface_normal_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// surface_normal_unit: surface normal at a ray hit point
// Sphere, flat surface and cylinder normals in fixed point, one item per cycle
// when not stalled, through a deep pipeline with a shared root and divide back end.
// ----------------------------------------------------------------------------
//
//  channel | handshake                 | payload
//  --------+---------------------------+----------------------------------------
//  hit     | hit_valid / hit_stall     | mode, hit_*, center_*, axis_*, radius
//  normal  | normal_valid/normal_stall | normal_x, normal_y, normal_z, degenerate
//
// Throughput is one item per cycle unless a result waits under normal_stall;
// an item passes 13 front stages, 32 square root stages (one root bit each),
// 32 divider stages (setup plus one quotient bit each) and the output register.
// All items, whatever their shape, run through the same stages in order.
// Reset clears only the stage valid bits; payload registers hold no reset.
// The pipeline advances as a whole: while a result waits under normal_stall,
// every stage holds and hit_stall is raised, so nothing is lost or repeated.
//
module surface_normal_unit (
  input  logic               clk,
  input  logic               rst,
  // hit channel
  input  logic               hit_valid,
  output logic               hit_stall,
  input  logic [1:0]         mode,
  input  logic signed [31:0] hit_x,
  input  logic signed [31:0] hit_y,
  input  logic signed [31:0] hit_z,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic signed [31:0] axis_x,
  input  logic signed [31:0] axis_y,
  input  logic signed [31:0] axis_z,
  input  logic [30:0]        radius,
  // normal channel
  output logic               normal_valid,
  input  logic               normal_stall,
  output logic signed [31:0] normal_x,
  output logic signed [31:0] normal_y,
  output logic signed [31:0] normal_z,
  output logic               degenerate
);

  // Advance every stage unless the finished item is held at the output
  logic adv;
  assign adv       = !(normal_valid && normal_stall);
  assign hit_stall = !adv;

  // --------------------------------------------------------------------------
  // Stage 1: offsets from the centre (exact, 33 bits)
  // --------------------------------------------------------------------------
  logic           s1_v;
  snu_pkg::base_t s1_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= hit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_b.mode   <= mode;
      s1_b.t[0]   <= 33'(hit_x) - 33'(center_x);
      s1_b.t[1]   <= 33'(hit_y) - 33'(center_y);
      s1_b.t[2]   <= 33'(hit_z) - 33'(center_z);
      s1_b.ax[0]  <= axis_x;
      s1_b.ax[1]  <= axis_y;
      s1_b.ax[2]  <= axis_z;
      s1_b.radius <= radius;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: t * axis, split into two partial products per lane
  // --------------------------------------------------------------------------
  logic             s2_v;
  snu_pkg::base_t   s2_b;
  logic [2:0][48:0] s2_hi;
  logic [2:0][47:0] s2_lo;
  logic [2:0]       s2_neg;
  logic [2:0][32:0] s1_tm;
  logic [2:0][31:0] s1_am;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_tm[i] = s1_b.t[i][32] ? 33'(-s1_b.t[i]) : s1_b.t[i];
      s1_am[i] = s1_b.ax[i][31] ? 32'(-s1_b.ax[i]) : s1_b.ax[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_b <= s1_b;
      for (int i = 0; i < 3; i++) begin
        s2_hi[i]  <= 49'(s1_tm[i][32:16]) * 49'(s1_am[i]);
        s2_lo[i]  <= 48'(s1_tm[i][15:0]) * 48'(s1_am[i]);
        s2_neg[i] <= s1_b.t[i][32] ^ s1_b.ax[i][31];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: assemble the products, drop 30 fraction bits, restore sign
  // --------------------------------------------------------------------------
  logic             s3_v;
  snu_pkg::base_t   s3_b;
  logic [2:0][34:0] s3_p;
  logic [2:0][64:0] s2_prod;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_prod[i] = {s2_hi[i], 16'b0} + 65'(s2_lo[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (adv) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_b <= s2_b;
      for (int i = 0; i < 3; i++) begin
        s3_p[i] <= s2_neg[i] ? -35'(s2_prod[i][63:snu_pkg::AXIS_FRAC])
                             : 35'(s2_prod[i][63:snu_pkg::AXIS_FRAC]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: projection length h along the axis
  // --------------------------------------------------------------------------
  logic           s4_v;
  snu_pkg::base_t s4_b;
  logic [35:0]    s4_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (adv) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_b <= s3_b;
      s4_h <= 36'($signed(s3_p[0])) + 36'($signed(s3_p[1])) + 36'($signed(s3_p[2]));
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: h * axis, split into two partial products per lane
  // --------------------------------------------------------------------------
  logic             s5_v;
  snu_pkg::base_t   s5_b;
  logic [2:0][49:0] s5_hi;
  logic [2:0][48:0] s5_lo;
  logic [2:0]       s5_neg;
  logic [35:0]      s4_hm;
  logic [2:0][31:0] s4_am;

  always_comb begin
    s4_hm = s4_h[35] ? -s4_h : s4_h;
    for (int i = 0; i < 3; i++) begin
      s4_am[i] = s4_b.ax[i][31] ? 32'(-s4_b.ax[i]) : s4_b.ax[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (adv) begin
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_b <= s4_b;
      for (int i = 0; i < 3; i++) begin
        s5_hi[i]  <= 50'(s4_hm[34:17]) * 50'(s4_am[i]);
        s5_lo[i]  <= 49'(s4_hm[16:0]) * 49'(s4_am[i]);
        s5_neg[i] <= s4_h[35] ^ s4_b.ax[i][31];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: assemble h * axis
  // --------------------------------------------------------------------------
  logic             s6_v;
  snu_pkg::base_t   s6_b;
  logic [2:0][37:0] s6_q;
  logic [2:0][66:0] s5_prod;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s5_prod[i] = {s5_hi[i], 17'b0} + 67'(s5_lo[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (adv) begin
      s6_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_b <= s5_b;
      for (int i = 0; i < 3; i++) begin
        s6_q[i] <= s5_neg[i] ? -38'(s5_prod[i][66:snu_pkg::AXIS_FRAC])
                             : 38'(s5_prod[i][66:snu_pkg::AXIS_FRAC]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: radial vector = t - h * axis
  // --------------------------------------------------------------------------
  logic             s7_v;
  snu_pkg::base_t   s7_b;
  logic [2:0][37:0] s7_rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
    end else if (adv) begin
      s7_v <= s6_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_b <= s6_b;
      for (int i = 0; i < 3; i++) begin
        s7_rad[i] <= 38'($signed(s6_b.t[i])) - s6_q[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: magnitudes and signs of the radial vector
  // --------------------------------------------------------------------------
  logic             s8_v;
  snu_pkg::base_t   s8_b;
  logic [2:0][36:0] s8_m;
  logic [2:0]       s8_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_v <= 1'b0;
    end else if (adv) begin
      s8_v <= s7_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_b <= s7_b;
      for (int i = 0; i < 3; i++) begin
        s8_m[i]   <= s7_rad[i][37] ? 37'(-s7_rad[i]) : s7_rad[i][36:0];
        s8_neg[i] <= s7_rad[i][37];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 9: largest magnitude
  // --------------------------------------------------------------------------
  logic             s9_v;
  snu_pkg::base_t   s9_b;
  logic [2:0][36:0] s9_m;
  logic [2:0]       s9_neg;
  logic [36:0]      s9_big;
  logic [36:0]      s8_max01;

  assign s8_max01 = (s8_m[1] > s8_m[0]) ? s8_m[1] : s8_m[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_v <= 1'b0;
    end else if (adv) begin
      s9_v <= s8_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_b   <= s8_b;
      s9_m   <= s8_m;
      s9_neg <= s8_neg;
      s9_big <= (s8_m[2] > s8_max01) ? s8_m[2] : s8_max01;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 10: shift that brings the largest magnitude into [2^30, 2^31)
  // --------------------------------------------------------------------------
  logic             s10_v;
  snu_pkg::base_t   s10_b;
  logic [2:0][36:0] s10_m;
  logic [2:0]       s10_neg;
  logic             s10_degen;
  logic             s10_right;
  logic [4:0]       s10_amt;
  logic [5:0]       s9_pos;
  logic             s9_right;

  always_comb begin
    s9_pos = '0;
    for (int k = 0; k < 37; k++) begin
      if (s9_big[k]) begin
        s9_pos = 6'(k);
      end
    end
    s9_right = s9_pos > 6'(snu_pkg::AXIS_FRAC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_v <= 1'b0;
    end else if (adv) begin
      s10_v <= s9_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s10_b     <= s9_b;
      s10_m     <= s9_m;
      s10_neg   <= s9_neg;
      s10_degen <= s9_big == '0;
      s10_right <= s9_right;
      s10_amt   <= s9_right ? 5'(s9_pos - 6'(snu_pkg::AXIS_FRAC))
                            : 5'(6'(snu_pkg::AXIS_FRAC) - s9_pos);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 11: shift all magnitudes together (right shifts truncate)
  // --------------------------------------------------------------------------
  logic             s11_v;
  snu_pkg::base_t   s11_b;
  snu_pkg::cyl_t    s11_c;
  logic [2:0][36:0] s10_sh;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s10_sh[i] = s10_right ? (s10_m[i] >> s10_amt) : (s10_m[i] << s10_amt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s11_v <= 1'b0;
    end else if (adv) begin
      s11_v <= s10_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s11_b       <= s10_b;
      s11_c.neg   <= s10_neg;
      s11_c.degen <= s10_degen;
      for (int i = 0; i < 3; i++) begin
        s11_c.m[i] <= s10_sh[i][30:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 12: squares
  // --------------------------------------------------------------------------
  logic             s12_v;
  snu_pkg::base_t   s12_b;
  snu_pkg::cyl_t    s12_c;
  logic [2:0][61:0] s12_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s12_v <= 1'b0;
    end else if (adv) begin
      s12_v <= s11_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s12_b <= s11_b;
      s12_c <= s11_c;
      for (int i = 0; i < 3; i++) begin
        s12_sq[i] <= 62'(s11_c.m[i]) * 62'(s11_c.m[i]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 13 and square root stages: one root bit per stage, MSB first.
  // Index 0 holds the sum of squares; index j has settled root bit 32 - j.
  // --------------------------------------------------------------------------
  logic [snu_pkg::SQRT_STEPS:0] sq_v;
  snu_pkg::base_t               sq_b   [0:snu_pkg::SQRT_STEPS];
  snu_pkg::cyl_t                sq_c   [0:snu_pkg::SQRT_STEPS];
  logic [63:0]                  sq_rem [0:snu_pkg::SQRT_STEPS];
  logic [31:0]                  sq_res [0:snu_pkg::SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (adv) begin
      sq_v[0] <= s12_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_b[0]   <= s12_b;
      sq_c[0]   <= s12_c;
      sq_rem[0] <= 64'(s12_sq[0]) + 64'(s12_sq[1]) + 64'(s12_sq[2]);
      sq_res[0] <= '0;
    end
  end

  for (genvar j = 1; j <= snu_pkg::SQRT_STEPS; j++) begin : g_sqrt
    localparam int K = snu_pkg::SQRT_STEPS - j;
    logic [64:0] trial;
    logic        ge;

    // (res + 2^K)^2 - res^2, with res holding only bits above K
    always_comb begin
      trial = (65'(sq_res[j-1]) << (K + 1)) + (65'(1) << (2 * K));
      ge    = {1'b0, sq_rem[j-1]} >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[j] <= 1'b0;
      end else if (adv) begin
        sq_v[j] <= sq_v[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_b[j]   <= sq_b[j-1];
        sq_c[j]   <= sq_c[j-1];
        sq_rem[j] <= ge ? 64'({1'b0, sq_rem[j-1]} - trial) : sq_rem[j-1];
        sq_res[j] <= ge ? (sq_res[j-1] | (32'(1) << K)) : sq_res[j-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divider setup: pick dividend and divisor by shape.
  // Sphere divides |d| by the radius, cylinder divides each normalized
  // magnitude by the length; both give a quotient below 2^31.
  // --------------------------------------------------------------------------
  localparam int SQL = snu_pkg::SQRT_STEPS;

  logic [snu_pkg::DIV_STEPS:0] dv_v;
  snu_pkg::tail_t              dv_tl  [0:snu_pkg::DIV_STEPS];
  logic [31:0]                 dv_d   [0:snu_pkg::DIV_STEPS];
  logic [2:0][32:0]            dv_rem [0:snu_pkg::DIV_STEPS];
  logic [2:0][30:0]            dv_q   [0:snu_pkg::DIV_STEPS];

  logic [2:0][32:0] su_md;
  logic [31:0]      su_twor;
  snu_pkg::tail_t   su_tl;
  logic [2:0][32:0] su_n;
  logic [31:0]      su_d;

  always_comb begin
    su_twor     = {sq_b[SQL].radius, 1'b0};
    su_tl.mode  = sq_b[SQL].mode;
    su_tl.ax    = sq_b[SQL].ax;
    su_tl.degen = sq_c[SQL].degen;
    for (int i = 0; i < 3; i++) begin
      su_md[i] = sq_b[SQL].t[i][32] ? 33'(-sq_b[SQL].t[i]) : sq_b[SQL].t[i];
      su_tl.zero[i] = su_md[i] == '0;
      su_tl.sat[i]  = (su_md[i] != '0) && (su_md[i] >= 33'(su_twor));
    end
    if (sq_b[SQL].mode == snu_pkg::MODE_CYLINDER) begin
      su_tl.neg = sq_c[SQL].neg;
      su_d      = sq_res[SQL];
      for (int i = 0; i < 3; i++) begin
        su_n[i] = 33'(sq_c[SQL].m[i]);
      end
    end else begin
      su_d = 32'(sq_b[SQL].radius);
      for (int i = 0; i < 3; i++) begin
        su_tl.neg[i] = sq_b[SQL].t[i][32];
        su_n[i]      = su_md[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= sq_v[SQL];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_tl[0]  <= su_tl;
      dv_d[0]   <= su_d;
      dv_rem[0] <= su_n;
      dv_q[0]   <= '0;
    end
  end

  // Divider stages: stage j settles quotient bit 31 - j. The first stage
  // compares the dividend as it is; later ones shift the remainder in.
  for (genvar j = 1; j <= snu_pkg::DIV_STEPS; j++) begin : g_div
    localparam int B = snu_pkg::DIV_STEPS - j;
    logic [2:0][33:0] rs;
    logic [2:0]       ge;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rs[i] = (j == 1) ? {1'b0, dv_rem[j-1][i]} : {dv_rem[j-1][i], 1'b0};
        ge[i] = rs[i] >= 34'(dv_d[j-1]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j] <= 1'b0;
      end else if (adv) begin
        dv_v[j] <= dv_v[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_tl[j] <= dv_tl[j-1];
        dv_d[j]  <= dv_d[j-1];
        for (int i = 0; i < 3; i++) begin
          dv_rem[j][i] <= ge[i] ? 33'(rs[i] - 34'(dv_d[j-1])) : rs[i][32:0];
          dv_q[j][i]   <= ge[i] ? (dv_q[j-1][i] | (31'(1) << B)) : dv_q[j-1][i];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: sign, saturation and shape select
  // --------------------------------------------------------------------------
  localparam int DVL = snu_pkg::DIV_STEPS;

  logic [2:0][31:0] ot_sq;
  logic [2:0][31:0] ot_n;
  logic             ot_degen;

  always_comb begin
    ot_degen = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ot_sq[i] = dv_tl[DVL].neg[i] ? -{1'b0, dv_q[DVL][i]} : {1'b0, dv_q[DVL][i]};
    end
    unique case (dv_tl[DVL].mode)
      snu_pkg::MODE_SPHERE: begin
        for (int i = 0; i < 3; i++) begin
          priority if (dv_tl[DVL].zero[i]) begin
            ot_n[i] = '0;
          end else if (dv_tl[DVL].sat[i]) begin
            ot_n[i] = dv_tl[DVL].neg[i] ? snu_pkg::SAT_NEG : snu_pkg::SAT_POS;
          end else begin
            ot_n[i] = ot_sq[i];
          end
        end
      end
      snu_pkg::MODE_FLAT: begin
        ot_n = dv_tl[DVL].ax;
      end
      snu_pkg::MODE_CYLINDER: begin
        ot_degen = dv_tl[DVL].degen;
        // drop the normal on a zero-length radial vector
        ot_n = dv_tl[DVL].degen ? '0 : ot_sq;
      end
      default: begin
        ot_n = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_valid <= 1'b0;
    end else if (adv) begin
      normal_valid <= dv_v[DVL];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      normal_x   <= ot_n[0];
      normal_y   <= ot_n[1];
      normal_z   <= ot_n[2];
      degenerate <= ot_degen;
    end
  end

endmodule
